@@ rtl/scp_pkg.sv @@
`default_nettype none
package scp_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    // magnitude of numerator after the fraction shift
    localparam int NUM_WIDTH = CROSS_WIDTH + FRAC_BITS;
    localparam int DEN_WIDTH = CROSS_WIDTH;
    // quotient bits that matter: 32 result bits plus one overflow bit
    localparam int QBITS = 33;
    // divisor aligned to the top quotient bit, shifted down one place per cell
    localparam int SHD_WIDTH = DEN_WIDTH + QBITS - 1;
    localparam int PARAM_WIDTH = 32;

    localparam logic [1:0] SIDE_ON = 2'd0;
    localparam logic [1:0] SIDE_LEFT = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // data moving along the divider chain
    typedef struct packed {
        logic                   vld;
        logic [NUM_WIDTH-1:0]   rem;
        logic [SHD_WIDTH-1:0]   den;
        logic [QBITS-1:0]       quo;
        logic                   ovf;
        logic                   neg;
        logic                   par;
        logic [1:0]             side;
    } div_t;
endpackage
`default_nettype wire

@@ rtl/segment_cross_param_and_side.sv @@
`default_nettype none
// Crossing parameter of two segment lines and side of a query point.
// Input channel: in_valid/in_ready with ten signed Q16.16 coordinates
// (reference segment, crossing segment, query point). Output channel:
// out_valid/out_ready with line_param (Q16.16, saturated), parallel,
// saturated and side_code (0 on line, 1 left, 2 right).
// One item is accepted per cycle while in_ready is high. From input
// transfer to result, data passes registers for differences, products
// and cross products, one overflow check, then a chain of 33 division
// cells, one quotient bit each, and a final saturation register.
// The whole pipeline advances together, one item per cycle unless stalled.
// When the receiver stalls with a result held, the pipeline freezes and
// in_ready drops; a skid-free hold keeps data intact, in_ready returns as
// soon as the output register is free or taken.
// Reset clears all valid flags; no results are pending after reset.
module segment_cross_param_and_side (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic signed [31:0] ref_start_x,
    input  wire logic signed [31:0] ref_start_y,
    input  wire logic signed [31:0] ref_end_x,
    input  wire logic signed [31:0] ref_end_y,
    input  wire logic signed [31:0] other_start_x,
    input  wire logic signed [31:0] other_start_y,
    input  wire logic signed [31:0] other_end_x,
    input  wire logic signed [31:0] other_end_y,
    input  wire logic signed [31:0] query_x,
    input  wire logic signed [31:0] query_y,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] line_param,
    output logic             parallel,
    output logic             saturated,
    output logic [1:0]       side_code
);
    localparam int QB = scp_pkg::QBITS;
    localparam int PW = scp_pkg::PARAM_WIDTH;

    logic           en;
    scp_pkg::div_t  chain [0:QB+1];
    scp_pkg::div_t  last;
    logic           ov_reg;
    logic [PW-1:0]  param_reg, param_next;
    logic           par_reg, sat_reg, sat_next;
    logic [1:0]     side_reg;
    logic [QB-1:0]  q;
    logic [PW-1:0]  lim;

    assign en = !out_valid || out_ready;
    assign in_ready = en;

    scp_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid && en),
        .sx(ref_start_x), .sy(ref_start_y), .ex(ref_end_x), .ey(ref_end_y),
        .ax(other_start_x), .ay(other_start_y), .bx(other_end_x), .by(other_end_y),
        .px(query_x), .py(query_y), .out(chain[0])
    );

    scp_ovf u_ovf (.clk(clk), .rst_n(rst_n), .en(en), .din(chain[0]), .dout(chain[1]));

    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        scp_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .din(chain[i+1]), .dout(chain[i+2])
        );
    end

    assign last = chain[QB+1];
    assign q = last.quo;

    always_comb
    begin
        lim = last.neg ? PW'(32'h8000_0000) : PW'(32'h7FFF_FFFF);
        sat_next = 1'b0;
        if (last.par)
            param_next = '0;
        else if (last.ovf || (q > QB'(lim)))
        begin
            sat_next = 1'b1;
            param_next = last.neg ? PW'(-lim) : lim;
        end
        else
            param_next = last.neg ? PW'(-q[PW-1:0]) : q[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= last.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            param_reg <= param_next;
            par_reg   <= last.par;
            sat_reg   <= sat_next;
            side_reg  <= last.side;
        end
    end

    assign out_valid   = ov_reg;
    assign line_param  = param_reg;
    assign parallel    = par_reg;
    assign saturated   = sat_reg;
    assign side_code   = side_reg;
endmodule
`default_nettype wire

@@ rtl/scp_front.sv @@
`default_nettype none
// differences, products and cross products, three registered stages
module scp_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  in_vld,
    input  wire logic signed [scp_pkg::COORD_WIDTH-1:0] sx,
    input  wire logic signed [scp_pkg::COORD_WIDTH-1:0] sy,
    input  wire logic signed [scp_pkg::COORD_WIDTH-1:0] ex,
    input  wire logic signed [scp_pkg::COORD_WIDTH-1:0] ey,
    input  wire logic signed [scp_pkg::COORD_WIDTH-1:0] ax,
    input  wire logic signed [scp_pkg::COORD_WIDTH-1:0] ay,
    input  wire logic signed [scp_pkg::COORD_WIDTH-1:0] bx,
    input  wire logic signed [scp_pkg::COORD_WIDTH-1:0] by,
    input  wire logic signed [scp_pkg::COORD_WIDTH-1:0] px,
    input  wire logic signed [scp_pkg::COORD_WIDTH-1:0] py,
    output scp_pkg::div_t                              out
);
    localparam int DW = scp_pkg::DIFF_WIDTH;
    localparam int PW = scp_pkg::PROD_WIDTH;
    localparam int CW = scp_pkg::CROSS_WIDTH;
    localparam int NW = scp_pkg::NUM_WIDTH;
    localparam int SH = scp_pkg::SHD_WIDTH;

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [DW-1:0] rdx_reg, rdy_reg, odx_reg, ody_reg;
    logic signed [DW-1:0] asx_reg, asy_reg, psx_reg, psy_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [CW-1:0] den_reg, num_reg, det_reg;
    logic signed [CW-1:0] den_next, num_next, det_next;
    logic [CW-1:0]        nmag, dmag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign den_next = CW'(p0_reg) - CW'(p1_reg);
    assign num_next = CW'(p2_reg) - CW'(p3_reg);
    assign det_next = CW'(p4_reg) - CW'(p5_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdx_reg <= DW'(ex) - DW'(sx);
            rdy_reg <= DW'(ey) - DW'(sy);
            odx_reg <= DW'(bx) - DW'(ax);
            ody_reg <= DW'(by) - DW'(ay);
            asx_reg <= DW'(ax) - DW'(sx);
            asy_reg <= DW'(ay) - DW'(sy);
            psx_reg <= DW'(px) - DW'(sx);
            psy_reg <= DW'(py) - DW'(sy);
            p0_reg  <= PW'(rdx_reg) * PW'(ody_reg);
            p1_reg  <= PW'(rdy_reg) * PW'(odx_reg);
            p2_reg  <= PW'(asx_reg) * PW'(ody_reg);
            p3_reg  <= PW'(asy_reg) * PW'(odx_reg);
            p4_reg  <= PW'(rdx_reg) * PW'(psy_reg);
            p5_reg  <= PW'(rdy_reg) * PW'(psx_reg);
            den_reg <= den_next;
            num_reg <= num_next;
            det_reg <= det_next;
        end
    end

    assign nmag = num_reg[CW-1] ? CW'(-num_reg) : CW'(num_reg);
    assign dmag = den_reg[CW-1] ? CW'(-den_reg) : CW'(den_reg);

    always_comb
    begin
        out.vld = v3_reg;
        out.rem = NW'(nmag) << scp_pkg::FRAC_BITS;
        // align divisor to the top quotient bit
        out.den = SH'(dmag) << (scp_pkg::QBITS - 1);
        out.quo = '0;
        out.ovf = 1'b0;
        out.neg = num_reg[CW-1] ^ den_reg[CW-1];
        out.par = (den_reg == '0);
        if (det_reg == '0)
            out.side = scp_pkg::SIDE_ON;
        else if (det_reg[CW-1])
            out.side = scp_pkg::SIDE_RIGHT;
        else
            out.side = scp_pkg::SIDE_LEFT;
    end
endmodule
`default_nettype wire

@@ rtl/scp_cell.sv @@
`default_nettype none
// one restoring division step, quotient bits enter from the bottom
module scp_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  scp_pkg::div_t      din,
    output scp_pkg::div_t      dout
);
    localparam int NW = scp_pkg::NUM_WIDTH;
    localparam int SH = scp_pkg::SHD_WIDTH;
    localparam int QB = scp_pkg::QBITS;

    scp_pkg::div_t          d_reg, d_next;
    logic                   fits;

    always_comb
    begin
        // divisor arrives already aligned to this cell's quotient bit
        fits = (SH'(din.rem) >= din.den);
        d_next = din;
        d_next.den = din.den >> 1;
        d_next.quo = {din.quo[QB-2:0], fits};
        if (fits)
        begin
            d_next.rem = NW'(SH'(din.rem) - din.den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg <= '0;
        else if (en)
            d_reg <= d_next;
    end

    assign dout = d_reg;
endmodule
`default_nettype wire

@@ rtl/scp_ovf.sv @@
`default_nettype none
// checks that the quotient stays below 2^QBITS before the division chain
module scp_ovf (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  scp_pkg::div_t  din,
    output scp_pkg::div_t  dout
);
    localparam int SW = scp_pkg::SHD_WIDTH + 1;

    scp_pkg::div_t d_reg;
    logic          big;

    // den already carries QBITS-1 of the shift, so one more gives den << QBITS
    assign big = (SW'(din.rem) >= (SW'(din.den) << 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg <= '0;
        else if (en)
        begin
            d_reg     <= din;
            d_reg.ovf <= big;
        end
    end

    assign dout = d_reg;
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 850;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 38;

    typedef struct {
        logic signed [31:0] sx, sy, ex, ey, ax, ay, bx, by, px, py;
    } segment_item_t;

    typedef struct {
        logic signed [31:0] param;
        logic               par;
        logic               sat;
        logic [1:0]         side;
    } crossing_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] ref_start_x = '0, ref_start_y = '0, ref_end_x = '0, ref_end_y = '0;
    logic signed [31:0] other_start_x = '0, other_start_y = '0;
    logic signed [31:0] other_end_x = '0, other_end_y = '0;
    logic signed [31:0] query_x = '0, query_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] line_param;
    logic parallel, saturated;
    logic [1:0] side_code;

    segment_item_t pending_items[$];
    crossing_t expected_crossings[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    bit in_taken = 0;
    bit sender_pause = 0;
    bit receiver_long_hold = 0;
    int send_gap = 0;
    int recv_gap = 0;

    segment_cross_param_and_side DUT (.*);

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic crossing_t predict_crossing(segment_item_t it);
        crossing_t r;
        logic signed [32:0] rdx, rdy, odx, ody, asx, asy, psx, psy;
        logic signed [67:0] den, num, det;
        logic [127:0] nmag, dmag, quo;
        bit neg;
        rdx = 33'(it.ex) - 33'(it.sx);
        rdy = 33'(it.ey) - 33'(it.sy);
        odx = 33'(it.bx) - 33'(it.ax);
        ody = 33'(it.by) - 33'(it.ay);
        asx = 33'(it.ax) - 33'(it.sx);
        asy = 33'(it.ay) - 33'(it.sy);
        psx = 33'(it.px) - 33'(it.sx);
        psy = 33'(it.py) - 33'(it.sy);
        den = 68'(rdx) * 68'(ody) - 68'(rdy) * 68'(odx);
        num = 68'(asx) * 68'(ody) - 68'(asy) * 68'(odx);
        det = 68'(rdx) * 68'(psy) - 68'(rdy) * 68'(psx);
        r.param = '0;
        r.par = 1'b0;
        r.sat = 1'b0;
        if (den == 0) begin
            r.par = 1'b1;
        end else begin
            neg = (num < 0) != (den < 0);
            nmag = num < 0 ? 128'(-num) : 128'(num);
            dmag = den < 0 ? 128'(-den) : 128'(den);
            quo = (nmag << scp_pkg::FRAC_BITS) / dmag;
            if (quo > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
                r.sat = 1'b1;
                r.param = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                r.param = neg ? -quo[31:0] : quo[31:0];
            end
        end
        r.side = det == 0 ? scp_pkg::SIDE_ON
                          : (det < 0 ? scp_pkg::SIDE_RIGHT : scp_pkg::SIDE_LEFT);
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            3: return 32'($signed($urandom_range(0, 65535)) - 32768) <<< 16;
            default: return 32'($signed($urandom_range(0, 2047)) - 1024) <<< 8;
        endcase
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 99) < 45) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_item(logic [31:0] sx, sy, ex, ey, ax, ay, bx, by, px, py);
        segment_item_t it;
        it.sx = sx; it.sy = sy; it.ex = ex; it.ey = ey;
        it.ax = ax; it.ay = ay; it.bx = bx; it.by = by;
        it.px = px; it.py = py;
        pending_items.push_back(it);
    endtask

    task automatic add_random_item();
        segment_item_t it;
        int shape;
        logic [31:0] t;
        it.sx = rand_coord(); it.sy = rand_coord();
        it.ex = rand_coord(); it.ey = rand_coord();
        it.ax = rand_coord(); it.ay = rand_coord();
        it.bx = rand_coord(); it.by = rand_coord();
        it.px = rand_coord(); it.py = rand_coord();
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            // other segment parallel to reference
            it.ax = it.sx + 32'($urandom_range(0, 255));
            it.ay = it.sy;
            it.bx = it.ax + (it.ex - it.sx);
            it.by = it.ay + (it.ey - it.sy);
        end else if (shape == 1) begin
            it.ex = it.sx; it.ey = it.sy;
        end else if (shape == 2) begin
            // query on the reference line
            it.px = it.ex; it.py = it.ey;
        end else if (shape == 3) begin
            // nearly parallel lines give huge parameters
            t = 32'($urandom_range(1, 3));
            it.bx = it.ax + (it.ex - it.sx);
            it.by = it.ay + (it.ey - it.sy) + t;
        end
        pending_items.push_back(it);
    endtask

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && in_taken) begin
                expected_crossings.push_back(predict_crossing(pending_items.pop_front()));
                send_gap = rand_gap();
            end
            if (in_valid && !in_taken) begin
            end else if (send_gap > 0 || sender_pause) begin
                if (send_gap > 0) send_gap--;
                in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_valid <= 1'b1;
                ref_start_x <= pending_items[0].sx;
                ref_start_y <= pending_items[0].sy;
                ref_end_x <= pending_items[0].ex;
                ref_end_y <= pending_items[0].ey;
                other_start_x <= pending_items[0].ax;
                other_start_y <= pending_items[0].ay;
                other_end_x <= pending_items[0].bx;
                other_end_y <= pending_items[0].by;
                query_x <= pending_items[0].px;
                query_y <= pending_items[0].py;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure, with one long hold-off in its own counter
    always @(negedge clk) begin
        if (rst_n) begin
            if (receiver_long_hold) begin
                receiver_long_hold = 0;
                hold_off = 150;
            end
            if (hold_off > 0) begin
                hold_off--;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                recv_gap = rand_gap();
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk) begin
        crossing_t e;
        in_taken <= in_valid && in_ready;
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
            if (out_valid && out_ready) begin
                if (expected_crossings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer: param %h", line_param);
                end else begin
                    e = expected_crossings.pop_front();
                    if (line_param !== e.param || parallel !== e.par || saturated !== e.sat
                        || side_code !== e.side) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
                                e.param, e.par, e.sat, e.side,
                                line_param, parallel, saturated, side_code);
                    end
                end
            end
        end
    end

    initial begin
        // extremes and special cases
        add_item(0, 0, 32'h0001_0000, 0, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_8000,
                 32'h0001_0000, 0, 32'h0001_0000);
        add_item(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 0, 32'hFFFF_0000);
        add_item(5, 5, 5, 5, 1, 2, 3, 4, 7, 9);
        add_item(0, 0, 32'h0001_0000, 0, 32'h0003_0000, 0, 32'h0004_0000, 0,
                 32'h0002_0000, 0);
        add_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000);
        add_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000);
        add_item(0, 0, 1, 0, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_0000, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(0, 0, 1, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 5, 0);
        add_item(0, 0, 0, 1, 32'hFFFF_FFFF, 32'h1234_5678, 1, 32'h1234_5678,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'h0000_0003, 0, 0, 32'h0000_0003,
                 32'h8000_0000, 32'h7FFF_FFFF);
        add_item(0, 0, 32'h0002_0000, 32'h0002_0000, 0, 32'h0002_0000, 32'h0002_0000, 0,
                 32'h0003_0000, 32'h0003_0000);
        add_item(0, 0, 3, 0, 1, 1, 1, 32'hFFFF_FFFF, 2, 0);
        add_item(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'hF0F0_F0F0, 32'h0F0F_0F0F,
                 32'h3333_3333, 32'hCCCC_CCCC);
        @(negedge clk);
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        wait (pending_items.size() == 0);
        // fill the pipeline while the output is held off
        receiver_long_hold = 1;
        for (int i = 0; i < 120; i++) add_random_item();
        wait (pending_items.size() == 0);
        // sender pause until drained
        sender_pause = 1;
        wait (expected_crossings.size() == 0);
        sender_pause = 0;
        for (int i = 0; i < N_RANDOM - 120; i++) add_random_item();
        wait (pending_items.size() == 0 && !in_valid);
        wait (expected_crossings.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_crossings.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
